// ===== rtl/core/srvramp_pkg.sv =====
`default_nettype none

package srvramp_pkg;

   localparam int PULSE_W   = 15;
   localparam int DELAY_W   = 16;
   localparam int PERIOD_W  = 8;
   localparam int ELAPSED_W = 17;
   localparam int SINCE_W   = 9;
   localparam int SPEED_W   = 8;
   localparam int PCT_W     = 16;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int SPAN_W    = PULSE_W + 1;
   localparam int PROD_W    = SPEED_W + SPAN_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SPEED = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ARM   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_DELAY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = 3'd4;

   localparam logic [PULSE_W-1:0]  RST_PULSE_MIN = 15'd1000;
   localparam logic [PULSE_W-1:0]  RST_PULSE_MID = 15'd1500;
   localparam logic [PULSE_W-1:0]  RST_PULSE_MAX = 15'd2000;
   localparam logic [DELAY_W-1:0]  RST_ARM_DELAY = 16'd5000;
   localparam logic [PERIOD_W-1:0] RST_PERIOD    = 8'd20;

   localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;
   localparam logic [SINCE_W-1:0]   SINCE_SAT   = '1;

   localparam logic signed [SPEED_W-1:0] SPEED_HI = 8'sd100;
   localparam logic signed [SPEED_W-1:0] SPEED_LO = -8'sd100;

   // floor(u/25) = (u * RECIP25) >> RECIP_SH, exact for u < 2^20
   localparam int RECIP_SH = 25;
   localparam int RECIP_W  = 21;
   localparam logic [RECIP_W-1:0] RECIP25 = 21'd1342178;
   localparam int MAG_W = 20;
   localparam int QUO_W = 15;

   typedef struct packed {
      logic               motor_armed;
      logic [PULSE_W-1:0] pulse_us;
      logic               pulse_written;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/servo_pulse_speed_ramp.sv =====
`default_nettype none

// Speed ramp for an RC speed controller. Each request transaction (ms tick,
// set speed, arm) gives one response, registered on the next cycle in the
// response register or, while a response is stalled, in the skid entry; with
// no response stall the block sustains one transaction per clock. The skid
// buffer holds one entry and lets one more request in during such a stall;
// req_stall rises only when that skid entry is full. The speed-times-span
// product is kept in a register updated every cycle, so the pulse update on
// a ramp tick is one add, a constant divide by 200 and a clamp. CSR writes
// are always ready and are meant to be issued only while the block is idle.
module servo_pulse_speed_ramp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [srvramp_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [srvramp_pkg::PCT_W-1:0]  req_speed_pct,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_motor_armed,
   output logic [srvramp_pkg::PULSE_W-1:0]            rsp_pulse_us,
   output logic                                       rsp_pulse_written,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [srvramp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [srvramp_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import srvramp_pkg::*;

   logic [PULSE_W-1:0]  pmin_ff, pmin_in, pmid_ff, pmid_in, pmax_ff, pmax_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   logic                       armed_ff, armed_in;
   logic [ELAPSED_W-1:0]       elapsed_ff, elapsed_in;
   logic [SINCE_W-1:0]         since_ff, since_in;
   logic signed [SPEED_W-1:0]  target_ff, target_in;
   logic signed [SPEED_W-1:0]  cur_ff, cur_in;
   logic [PULSE_W-1:0]         pulse_ff, pulse_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic accept, drain, csr_wr;
   logic [SINCE_W-1:0] since_inc;
   logic step_up, step_dn, do_write;
   logic signed [SPEED_W-1:0] pct_clamped;
   logic signed [SPAN_W-1:0]  span_ff, span_in;

   // pulse computation
   logic signed [PROD_W:0]    sum;
   logic signed [PROD_W-3:0]  q8;
   logic                      neg;
   logic [PROD_W-3:0]         q8_abs;
   logic [MAG_W-1:0]          mag;
   logic [MAG_W+RECIP_W-1:0]  recip_prod;
   logic [QUO_W-1:0]          quo;
   logic signed [QUO_W:0]     quo_s;
   logic signed [PULSE_W+2:0] x, lo, hi;
   logic [PULSE_W-1:0]        new_pulse;

   assign accept    = req_valid && !req_stall;
   assign drain     = out_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign req_stall = skid_valid_ff;

   // configuration registers
   always_comb begin
      pmin_in   = pmin_ff;
      pmid_in   = pmid_ff;
      pmax_in   = pmax_ff;
      delay_in  = delay_ff;
      period_in = period_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_PULSE_MIN: pmin_in   = csr_wdata[PULSE_W-1:0];
            CSR_PULSE_MID: pmid_in   = csr_wdata[PULSE_W-1:0];
            CSR_PULSE_MAX: pmax_in   = csr_wdata[PULSE_W-1:0];
            CSR_ARM_DELAY: delay_in  = csr_wdata[DELAY_W-1:0];
            CSR_PERIOD:    period_in = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   assign span_ff = $signed({1'b0, pmax_ff}) - $signed({1'b0, pmin_ff});
   assign span_in = $signed({1'b0, pmax_in}) - $signed({1'b0, pmin_in});

   always_comb begin
      if (req_speed_pct > PCT_W'(SPEED_HI))
         pct_clamped = SPEED_HI;
      else if (req_speed_pct < PCT_W'(SPEED_LO))
         pct_clamped = SPEED_LO;
      else
         pct_clamped = req_speed_pct[SPEED_W-1:0];
   end

   assign since_inc = (since_ff == SINCE_SAT) ? since_ff : since_ff + 1'b1;

   // ramp control
   always_comb begin
      armed_in   = armed_ff;
      elapsed_in = elapsed_ff;
      since_in   = since_ff;
      target_in  = target_ff;
      cur_in     = cur_ff;
      step_up    = 1'b0;
      step_dn    = 1'b0;
      do_write   = 1'b0;
      if (accept) begin
         unique case (req_command)
            CMD_TICK: begin
               elapsed_in = (elapsed_ff == ELAPSED_SAT) ? elapsed_ff : elapsed_ff + 1'b1;
               since_in   = since_inc;
               if (since_inc > {1'b0, period_ff}) begin
                  since_in = '0;
                  if (armed_ff) begin
                     do_write = 1'b1;
                     step_up  = cur_ff < target_ff;
                     step_dn  = cur_ff > target_ff;
                     if (step_up)
                        cur_in = cur_ff + 8'sd1;
                     else if (step_dn)
                        cur_in = cur_ff - 8'sd1;
                  end
               end
            end
            CMD_SPEED: begin
               if (armed_ff)
                  target_in = pct_clamped;
            end
            CMD_ARM: begin
               if (!armed_ff && elapsed_ff > {1'b0, delay_ff}) begin
                  armed_in  = 1'b1;
                  target_in = '0;
                  cur_in    = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // prod_ff always holds cur_ff * span_ff; a step only adds or subtracts one span
   assign prod_in = PROD_W'(cur_in) * PROD_W'(span_in);

   always_comb begin
      sum = {prod_ff[PROD_W-1], prod_ff};
      if (step_up)
         sum = sum + (PROD_W+1)'(span_ff);
      else if (step_dn)
         sum = sum - (PROD_W+1)'(span_ff);
      // floor(s/200) = floor(floor(s/8)/25)
      q8     = sum[PROD_W:3];
      neg    = q8[PROD_W-3];
      q8_abs = neg ? (~q8 + 1'b1) : q8;
      mag    = q8_abs[MAG_W-1:0] + (neg ? MAG_W'(24) : MAG_W'(0));
      recip_prod = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(RECIP25);
      quo    = recip_prod[RECIP_SH +: QUO_W];
      quo_s  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      x      = $signed({3'b000, pmid_ff}) + (PULSE_W+3)'(quo_s);
      lo     = $signed({3'b000, pmin_ff});
      hi     = $signed({3'b000, pmax_ff});
      priority if (x < lo)
         new_pulse = pmin_ff;
      else if (x > hi)
         new_pulse = pmax_ff;
      else
         new_pulse = x[PULSE_W-1:0];
   end

   assign pulse_in = do_write ? new_pulse : pulse_ff;

   // response register plus skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || drain) begin
            out_in.motor_armed   = armed_in;
            out_in.pulse_us      = pulse_in;
            out_in.pulse_written = do_write;
            out_valid_in         = 1'b1;
         end else begin
            skid_in.motor_armed   = armed_in;
            skid_in.pulse_us      = pulse_in;
            skid_in.pulse_written = do_write;
            skid_valid_in         = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff       <= RST_PULSE_MIN;
         pmid_ff       <= RST_PULSE_MID;
         pmax_ff       <= RST_PULSE_MAX;
         delay_ff      <= RST_ARM_DELAY;
         period_ff     <= RST_PERIOD;
         armed_ff      <= 1'b0;
         elapsed_ff    <= '0;
         since_ff      <= '0;
         target_ff     <= '0;
         cur_ff        <= '0;
         pulse_ff      <= RST_PULSE_MID;
         prod_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pmin_ff       <= pmin_in;
         pmid_ff       <= pmid_in;
         pmax_ff       <= pmax_in;
         delay_ff      <= delay_in;
         period_ff     <= period_in;
         armed_ff      <= armed_in;
         elapsed_ff    <= elapsed_in;
         since_ff      <= since_in;
         target_ff     <= target_in;
         cur_ff        <= cur_in;
         pulse_ff      <= pulse_in;
         prod_ff       <= prod_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_motor_armed   = out_ff.motor_armed;
   assign rsp_pulse_us      = out_ff.pulse_us;
   assign rsp_pulse_written = out_ff.pulse_written;

   a_written_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pulse_written |-> rsp_motor_armed)
      else $error("pulse written while idle");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full with empty response register");

   a_armed_sticks: assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("armed state dropped");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= SPEED_HI && cur_ff >= SPEED_LO && target_ff <= SPEED_HI && target_ff >= SPEED_LO)
      else $error("speed out of range");

endmodule

`default_nettype wire
